// ===== src/sktbl_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none
package sktbl_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 32;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_SEARCH = 2'd1;
	localparam logic [1:0] FUNC_TOGGLE = 2'd2;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_APPENDED = 3'd2,
		ST_INSERTED = 3'd3,
		ST_DELETED  = 3'd4,
		ST_FULL     = 3'd5,
		ST_ORDER    = 3'd6
	} res_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APP_CHK,
		S_APP_CMP,
		S_BS_CHK,
		S_BS_CMP,
		S_FIND_CHK,
		S_DEL_CHK,
		S_DEL_WR,
		S_INS_CHK,
		S_INS_WR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_LAST,
		RD_MID,
		RD_LO,
		RD_NEXT,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_SHIFT,
		WR_KEY_LO,
		WR_KEY_CNT
	} wr_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_LO,
		PTR_CNT,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		POS_ZERO,
		POS_LO,
		POS_CNT
	} pos_sel_t;

	typedef struct packed {
		logic      load;
		logic      step;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wr_sel_t   wr_sel;
		ptr_op_t   ptr_op;
		cnt_op_t   cnt_op;
		logic      res_set;
		res_code_t res_code;
		pos_sel_t  pos_sel;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_toggle;
		logic empty;
		logic full;
		logic less;
		logic match;
		logic bs_more;
		logic lo_lt_cnt;
		logic del_more;
		logic ins_more;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/sktbl_ctrl.sv =====
// Controller state machine that sequences search, append, insert and delete requests.
`timescale 1ns / 1ps
`default_nettype none
module sktbl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         func,
	output logic                    in_stall,
	input  wire sktbl_pkg::dp_stat_t stat,
	output sktbl_pkg::dp_cmd_t      cmd
);
	import sktbl_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   resolve;
	logic   found;

	// A search is resolved when no candidate remains or the candidate has been read.
	always_comb begin
		resolve = 1'b0;
		found   = 1'b0;
		if (state_q == S_BS_CHK) begin
			resolve = !stat.bs_more && !stat.lo_lt_cnt;
		end else if (state_q == S_FIND_CHK) begin
			resolve = 1'b1;
			found   = stat.match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = (func == FUNC_APPEND) ? S_APP_CHK : S_BS_CHK;
				end
			end
			S_APP_CHK: begin
				if (stat.full || stat.empty) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_APP_CMP;
				end
			end
			S_APP_CMP: state_nx = S_DONE;
			S_BS_CHK, S_FIND_CHK: begin
				if (resolve) begin
					if (!stat.is_toggle) begin
						state_nx = S_DONE;
					end else if (found) begin
						state_nx = S_DEL_CHK;
					end else if (stat.full) begin
						state_nx = S_DONE;
					end else begin
						state_nx = S_INS_CHK;
					end
				end else if (stat.bs_more) begin
					state_nx = S_BS_CMP;
				end else begin
					state_nx = S_FIND_CHK;
				end
			end
			S_BS_CMP: state_nx = S_BS_CHK;
			S_DEL_CHK: state_nx = stat.del_more ? S_DEL_WR : S_DONE;
			S_DEL_WR:  state_nx = S_DEL_CHK;
			S_INS_CHK: state_nx = stat.ins_more ? S_INS_WR : S_DONE;
			S_INS_WR:  state_nx = S_INS_CHK;
			S_DONE: begin
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != S_IDLE);
		cmd          = '0;
		cmd.rd_sel   = RD_LAST;
		cmd.wr_sel   = WR_SHIFT;
		cmd.ptr_op   = PTR_HOLD;
		cmd.cnt_op   = CNT_HOLD;
		cmd.res_code = ST_NOTFOUND;
		cmd.pos_sel  = POS_ZERO;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_APP_CHK: begin
				if (stat.full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_FULL;
				end else if (stat.empty) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_KEY_CNT;
					cmd.cnt_op   = CNT_INC;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_APPENDED;
					cmd.pos_sel  = POS_CNT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LAST;
				end
			end
			S_APP_CMP: begin
				cmd.res_set = 1'b1;
				if (stat.less) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_KEY_CNT;
					cmd.cnt_op   = CNT_INC;
					cmd.res_code = ST_APPENDED;
					cmd.pos_sel  = POS_CNT;
				end else begin
					cmd.res_code = ST_ORDER;
				end
			end
			S_BS_CHK, S_FIND_CHK: begin
				if (resolve) begin
					if (!stat.is_toggle) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = found ? ST_FOUND : ST_NOTFOUND;
						cmd.pos_sel  = found ? POS_LO : POS_ZERO;
					end else if (found) begin
						cmd.ptr_op = PTR_LO;
					end else if (stat.full) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_FULL;
					end else begin
						cmd.ptr_op = PTR_CNT;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = stat.bs_more ? RD_MID : RD_LO;
				end
			end
			S_BS_CMP: begin
				cmd.step = 1'b1;
			end
			S_DEL_CHK: begin
				if (stat.del_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end else begin
					cmd.cnt_op   = CNT_DEC;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_DELETED;
					cmd.pos_sel  = POS_LO;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.ptr_op = PTR_INC;
			end
			S_INS_CHK: begin
				if (stat.ins_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_KEY_LO;
					cmd.cnt_op   = CNT_INC;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_INSERTED;
					cmd.pos_sel  = POS_LO;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.ptr_op = PTR_DEC;
			end
			S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/sktbl_dp.sv =====
// Datapath with the key memory, entry count, search bounds, shift pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module sktbl_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [1:0]             func,
	input  wire logic signed [31:0]     key,
	input  wire sktbl_pkg::dp_cmd_t     cmd,
	output sktbl_pkg::dp_stat_t         stat,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [2:0]                  status,
	output logic [5:0]                  position,
	output logic [6:0]                  entry_total
);
	import sktbl_pkg::*;

	logic [KW-1:0] mem [DEPTH];
	logic [KW-1:0] rd_q;
	logic [KW-1:0] key_q;
	logic [1:0]    func_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] ptr_q;
	res_code_t     res_code_q;
	logic [CW-1:0] res_pos_q;
	logic [2:0]    status_q;
	logic [5:0]    position_q;
	logic [6:0]    total_q;
	logic          out_valid_q;

	logic [CW:0]   bound_sum;
	logic [CW-1:0] mid;
	logic [CW-1:0] rd_addr_w;
	logic [CW-1:0] wr_addr_w;
	logic [KW-1:0] wr_data;

	assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = bound_sum[CW:1];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_LAST: rd_addr_w = count_q - 1'b1;
			RD_MID:  rd_addr_w = mid;
			RD_LO:   rd_addr_w = lo_q;
			RD_NEXT: rd_addr_w = ptr_q + 1'b1;
			RD_PREV: rd_addr_w = ptr_q - 1'b1;
			default: rd_addr_w = lo_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_addr_w = ptr_q;
				wr_data   = rd_q;
			end
			WR_KEY_LO: begin
				wr_addr_w = lo_q;
				wr_data   = key_q;
			end
			WR_KEY_CNT: begin
				wr_addr_w = count_q;
				wr_data   = key_q;
			end
			default: begin
				wr_addr_w = ptr_q;
				wr_data   = rd_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr_w[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr_w[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key;
			lo_q   <= '0;
			hi_q   <= count_q;
		end else if (cmd.step) begin
			if (stat.less) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
		end
		unique case (cmd.ptr_op)
			PTR_HOLD: ptr_q <= ptr_q;
			PTR_LO:   ptr_q <= lo_q;
			PTR_CNT:  ptr_q <= count_q;
			PTR_INC:  ptr_q <= ptr_q + 1'b1;
			PTR_DEC:  ptr_q <= ptr_q - 1'b1;
			default:  ptr_q <= ptr_q;
		endcase
		if (cmd.res_set) begin
			res_code_q <= cmd.res_code;
			unique case (cmd.pos_sel)
				POS_ZERO: res_pos_q <= '0;
				POS_LO:   res_pos_q <= lo_q;
				POS_CNT:  res_pos_q <= count_q;
				default:  res_pos_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			status_q   <= res_code_q;
			position_q <= 6'(res_pos_q);
			total_q    <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + 1'b1;
				CNT_DEC:  count_q <= count_q - 1'b1;
				default:  count_q <= count_q;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.is_toggle = (func_q == FUNC_TOGGLE);
		stat.empty     = (count_q == '0);
		stat.full      = (count_q == CW'(DEPTH));
		stat.less      = ($signed(rd_q) < $signed(key_q));
		stat.match     = (rd_q == key_q);
		stat.bs_more   = (lo_q < hi_q);
		stat.lo_lt_cnt = (lo_q < count_q);
		stat.del_more  = ((ptr_q + 1'b1) < count_q);
		stat.ins_more  = (ptr_q > lo_q);
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_total = total_q;

endmodule
`default_nettype wire

// ===== src/sorted_key_table.sv =====
// Top level of the sorted key table: controller and datapath joined by command and status.
// A toggle shifts keys through the key memory to delete or insert a key. One request is
// worked on at a time; the next can be accepted as soon as a result is offered, while that
// result waits in the output register.
// Reset clears the entry count and control state; key memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic signed [31:0] key,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [5:0]              position,
	output logic [6:0]              entry_total
);
	import sktbl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sktbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sktbl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.key         (key),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.position    (position),
		.entry_total (entry_total)
	);

endmodule
`default_nettype wire
